// File: src/pool_pkg.sv
// ----------------------------------------------------------------------------
// pool_pkg: shared types and constants for the 2-D pooling core
// Register indexes, configuration struct and controller/datapath command.
// ----------------------------------------------------------------------------
package pool_pkg;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 12;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_HEIGHT  = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_WINDOW_HEIGHT = 3'd3,
		REG_WINDOW_WIDTH  = 3'd4,
		REG_STEP_ROWS     = 3'd5,
		REG_STEP_COLS     = 3'd6,
		REG_MAX_MODE      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] image_height;
		logic [8:0]  image_width;
		logic [11:0] channel_count;
		logic [3:0]  window_height;
		logic [3:0]  window_width;
		logic [3:0]  step_rows;
		logic [3:0]  step_cols;
		logic        max_mode;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic clear;   // start a new window
		logic accum;   // fold the read data of the previous cycle
		logic divide;  // start the average division
		logic load;    // load result register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} dp_sts_t;

endpackage

// File: src/pool_stream_if.sv
// ----------------------------------------------------------------------------
// pool_stream_if: valid/ready stream channel
// Carries one payload per transfer.
// ----------------------------------------------------------------------------
interface pool_stream_if #(
	parameter int WIDTH = 16
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/pooling_2d_max_avg_core.sv
// ----------------------------------------------------------------------------
// pooling_2d_max_avg_core: streaming 2-D max / average pooling
// A pixel that is not the bottom-right corner of a window fitting the image
// is taken with no further work. For a corner pixel the core tests its window
// origin against the stride grid (bit-serial remainder); off the grid it is
// then done. On the grid it walks the window through line-store reads (one
// read port), folds the last word, in average mode runs the bit-serial
// division, and then loads the output register. The load waits while an
// earlier result is still shown; the output register lets the core keep
// taking pixels meanwhile.
// The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module pooling_2d_max_avg_core #(
	parameter int MAX_IMAGE_WIDTH = 256,
	parameter int MAX_WINDOW      = 8,
	parameter int PIXEL_BITS      = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pool_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pool_pkg::CFG_DATA_BITS-1:0] cfg_data,
	pool_stream_if.sink                        pixel_in,
	pool_stream_if.source                      pooled_out
);
	import pool_pkg::*;

	localparam int DEPTH     = MAX_WINDOW * MAX_IMAGE_WIDTH;
	localparam int AREA_BITS = 2 * $clog2(MAX_WINDOW + 1);

	cfg_t                     cfg_q;
	dp_cmd_t                  cmd;
	dp_sts_t                  sts;
	logic                     we;
	logic [$clog2(DEPTH)-1:0] waddr;
	logic [$clog2(DEPTH)-1:0] raddr;
	logic [PIXEL_BITS-1:0]    rdata;
	logic [PIXEL_BITS-1:0]    result;
	logic                     frame_last;
	logic [7:0]               area_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{image_height: 12'd256, image_width: 9'd256, channel_count: 12'd1,
				window_height: 4'd2, window_width: 4'd2, step_rows: 4'd2,
				step_cols: 4'd2, max_mode: 1'b1};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data;
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[8:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data;
				REG_WINDOW_HEIGHT: cfg_q.window_height <= cfg_data[3:0];
				REG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg_data[3:0];
				REG_STEP_ROWS:     cfg_q.step_rows     <= cfg_data[3:0];
				REG_STEP_COLS:     cfg_q.step_cols     <= cfg_data[3:0];
				REG_MAX_MODE:      cfg_q.max_mode      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign area_full = {4'b0, cfg_q.window_height} * {4'b0, cfg_q.window_width};

	pool_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(pixel_in.data[PIXEL_BITS-1:0]),
		.raddr(raddr), .rdata(rdata)
	);

	pool_ctrl #(.MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(pixel_in.valid), .in_ready(pixel_in.ready),
		.out_valid(pooled_out.valid), .out_ready(pooled_out.ready),
		.frame_last(frame_last), .we(we), .waddr(waddr), .raddr(raddr),
		.cmd(cmd), .sts(sts)
	);

	pool_datapath #(.PIXEL_BITS(PIXEL_BITS), .MAX_WINDOW(MAX_WINDOW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .max_mode(cfg_q.max_mode),
		.rdata(rdata), .area(AREA_BITS'(area_full)), .result(result)
	);

	assign pooled_out.data = {frame_last, result};
endmodule

// File: src/pool_ram.sv
// ----------------------------------------------------------------------------
// pool_ram: generic single-write, single-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module pool_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: src/pool_datapath.sv
// ----------------------------------------------------------------------------
// pool_datapath: window accumulator and average divider
// Folds store words into a max or a sum, then divides the sum by the area
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pool_datapath #(
	parameter int PIXEL_BITS = 16,
	parameter int MAX_WINDOW = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pool_pkg::dp_cmd_t       cmd,
	output pool_pkg::dp_sts_t       sts,
	input  logic                    max_mode,
	input  logic [PIXEL_BITS-1:0]   rdata,
	input  logic [2*$clog2(MAX_WINDOW+1)-1:0] area,
	output logic [PIXEL_BITS-1:0]   result
);
	import pool_pkg::*;

	localparam int AREA_BITS = 2 * $clog2(MAX_WINDOW + 1);
	localparam int ACC_BITS  = PIXEL_BITS + AREA_BITS;
	localparam int CNT_BITS  = $clog2(ACC_BITS + 1);

	logic signed [ACC_BITS-1:0] acc_q;
	logic                       first_q;
	logic [ACC_BITS-1:0]        quo_q;
	logic [ACC_BITS-1:0]        rem_q;
	logic                       neg_q;
	logic [CNT_BITS-1:0]        cnt_q;
	logic                       busy_q;
	logic signed [ACC_BITS-1:0] val;
	logic [ACC_BITS:0]          trial;
	logic [ACC_BITS-1:0]        mag;
	logic [ACC_BITS-1:0]        quo_signed;

	assign val   = ACC_BITS'(signed'(rdata));
	assign mag   = acc_q[ACC_BITS-1] ? ACC_BITS'(-acc_q) : ACC_BITS'(acc_q);
	assign trial = {rem_q, quo_q[ACC_BITS-1]} - {{(ACC_BITS+1-AREA_BITS){1'b0}}, area};
	assign quo_signed = neg_q ? ACC_BITS'(-quo_q) : quo_q;
	assign sts.div_done = busy_q && (cnt_q == CNT_BITS'(ACC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			first_q <= 1'b1;
		end else begin
			if (cmd.clear) begin
				first_q <= 1'b1;
				acc_q   <= '0;
			end else if (cmd.accum) begin
				first_q <= 1'b0;
				if (max_mode) begin
					if (first_q || val > acc_q) begin
						acc_q <= val;
					end
				end else begin
					acc_q <= acc_q + val;
				end
			end
			if (cmd.divide) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= acc_q[ACC_BITS-1];
				quo_q  <= mag;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_BITS'(ACC_BITS)) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (!trial[ACC_BITS]) begin
						rem_q <= trial[ACC_BITS-1:0];
						quo_q <= {quo_q[ACC_BITS-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[ACC_BITS-2:0], quo_q[ACC_BITS-1]};
						quo_q <= {quo_q[ACC_BITS-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			result <= max_mode ? acc_q[PIXEL_BITS-1:0] : quo_signed[PIXEL_BITS-1:0];
		end
	end

	ast_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.divide |=> busy_q && cnt_q == '0)
		else $error("divider did not start");
	ast_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !sts.div_done |-> !cmd.load)
		else $error("result loaded during division");
	ast_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= CNT_BITS'(ACC_BITS))
		else $error("divider count overrun");
endmodule

// File: src/pool_ctrl.sv
// ----------------------------------------------------------------------------
// pool_ctrl: position tracking and window read sequencer
// Writes each in-image pixel into the line store (when the geometry is valid),
// tests whether it closes a window on the stride grid, then walks the window addresses one per cycle.
// ----------------------------------------------------------------------------
module pool_ctrl #(
	parameter int MAX_IMAGE_WIDTH = 256,
	parameter int MAX_WINDOW      = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pool_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  frame_last,
	output logic                  we,
	output logic [$clog2(MAX_WINDOW*MAX_IMAGE_WIDTH)-1:0] waddr,
	output logic [$clog2(MAX_WINDOW*MAX_IMAGE_WIDTH)-1:0] raddr,
	output pool_pkg::dp_cmd_t     cmd,
	input  pool_pkg::dp_sts_t     sts
);
	import pool_pkg::*;

	localparam int COL_BITS = $clog2(MAX_IMAGE_WIDTH);
	localparam int ROW_SEL  = $clog2(MAX_WINDOW);
	localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
	localparam int POS_BITS = 12;

	typedef enum logic [2:0] {
		S_IDLE, S_ALIGN, S_READ, S_FOLD, S_LAST, S_DIV, S_OUT
	} state_t;

	state_t               state_q;
	logic [11:0]          row_q;
	logic [11:0]          col_q;
	logic [11:0]          ch_q;
	logic [11:0]          top_q;
	logic [11:0]          left_q;
	logic [WIN_BITS-1:0]  dy_q;
	logic [WIN_BITS-1:0]  dx_q;
	logic [3:0]           bit_q;
	logic [3:0]           trem_q;
	logic [3:0]           lrem_q;
	logic                 last_q;
	logic                 accum_q;
	logic                 geom_ok;
	logic                 in_img;
	logic                 corner;
	logic                 accept;
	logic                 out_load;
	logic [11:0]          top_c;
	logic [11:0]          left_c;
	logic [11:0]          last_top;
	logic [11:0]          last_left;
	logic [11:0]          r_abs;
	logic [11:0]          c_abs;
	logic                 col_wrap;
	logic                 row_wrap;
	logic [4:0]           trem_sh;
	logic [4:0]           lrem_sh;
	logic [4:0]           trem_nx;
	logic [4:0]           lrem_nx;

	assign geom_ok = cfg.image_width != '0
		&& {3'b0, cfg.image_width} <= 12'(MAX_IMAGE_WIDTH)
		&& cfg.window_height != '0 && 32'(cfg.window_height) <= MAX_WINDOW
		&& cfg.window_width != '0 && 32'(cfg.window_width) <= MAX_WINDOW
		&& cfg.step_rows != '0 && cfg.step_cols != '0
		&& {8'b0, cfg.window_height} <= cfg.image_height
		&& {5'b0, cfg.window_width} <= {3'b0, cfg.image_width};
	assign in_img = row_q < cfg.image_height && col_q < {3'b0, cfg.image_width}
		&& ch_q < cfg.channel_count;
	assign top_c  = row_q + 12'd1 - {8'b0, cfg.window_height};
	assign left_c = col_q + 12'd1 - {8'b0, cfg.window_width};
	// bottom-right corner of a window that fits; the grid test follows
	assign corner = geom_ok && in_img && row_q + 12'd1 >= {8'b0, cfg.window_height}
		&& col_q + 12'd1 >= {8'b0, cfg.window_width};
	assign accept = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;
	assign we = accept && geom_ok && in_img;
	assign waddr = {row_q[ROW_SEL-1:0], col_q[COL_BITS-1:0]};
	assign r_abs = top_q + {{(12-WIN_BITS){1'b0}}, dy_q};
	assign c_abs = left_q + {{(12-WIN_BITS){1'b0}}, dx_q};
	assign raddr = {r_abs[ROW_SEL-1:0], c_abs[COL_BITS-1:0]};
	// current window origins; the last-result test checks whether their next
	// step along the stride grid would leave the image
	assign last_top  = top_c;
	assign last_left = left_c;
	assign col_wrap = col_q + 12'd1 >= {3'b0, cfg.image_width};
	assign row_wrap = row_q + 12'd1 >= cfg.image_height;

	// origin mod stride, one dividend bit per cycle, MSB first
	assign trem_sh = {trem_q, top_q[4'(POS_BITS - 1) - bit_q]};
	assign lrem_sh = {lrem_q, left_q[4'(POS_BITS - 1) - bit_q]};
	assign trem_nx = (trem_sh >= {1'b0, cfg.step_rows})
		? trem_sh - {1'b0, cfg.step_rows} : trem_sh;
	assign lrem_nx = (lrem_sh >= {1'b0, cfg.step_cols})
		? lrem_sh - {1'b0, cfg.step_cols} : lrem_sh;

	assign out_load = state_q == S_OUT && (!out_valid || out_ready);

	always_comb begin
		cmd.clear  = accept && corner;
		cmd.accum  = accum_q;
		cmd.divide = state_q == S_LAST && !cfg.max_mode;
		cmd.load   = out_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_q      <= '0;
			col_q      <= '0;
			ch_q       <= '0;
			bit_q      <= '0;
			trem_q     <= '0;
			lrem_q     <= '0;
			accum_q    <= 1'b0;
			out_valid  <= 1'b0;
			frame_last <= 1'b0;
			dy_q       <= '0;
			dx_q       <= '0;
			last_q     <= 1'b0;
		end else begin
			accum_q <= state_q == S_READ;
			// hold the shown result until its transfer, then refill
			if (out_load) begin
				out_valid  <= 1'b1;
				frame_last <= last_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (corner) begin
							top_q  <= top_c;
							left_q <= left_c;
							dy_q   <= '0;
							dx_q   <= '0;
							bit_q  <= '0;
							trem_q <= '0;
							lrem_q <= '0;
							// last result: last channel, and no further origin fits in either axis
							last_q <= ch_q + 12'd1 == cfg.channel_count
								&& {1'b0, last_top} + {9'b0, cfg.step_rows}
									> {1'b0, cfg.image_height}
									- {9'b0, cfg.window_height}
								&& {1'b0, last_left} + {9'b0, cfg.step_cols}
									> {4'b0, cfg.image_width}
									- {9'b0, cfg.window_width};
							state_q <= S_ALIGN;
						end
						if (col_wrap) begin
							col_q <= '0;
							if (row_wrap) begin
								row_q <= '0;
								ch_q <= (ch_q + 12'd1 >= cfg.channel_count) ? '0
									: ch_q + 12'd1;
							end else begin
								row_q <= row_q + 12'd1;
							end
						end else begin
							col_q <= col_q + 12'd1;
						end
					end
				end
				S_ALIGN: begin
					if (bit_q == 4'(POS_BITS - 1)) begin
						state_q <= (trem_nx == '0 && lrem_nx == '0) ? S_READ : S_IDLE;
					end else begin
						bit_q  <= bit_q + 4'd1;
						trem_q <= trem_nx[3:0];
						lrem_q <= lrem_nx[3:0];
					end
				end
				S_READ: begin
					if ({{(4-WIN_BITS+1){1'b0}}, dx_q} + 5'd1 >= {1'b0, cfg.window_width}) begin
						dx_q <= '0;
						if ({{(4-WIN_BITS+1){1'b0}}, dy_q} + 5'd1
							>= {1'b0, cfg.window_height}) begin
							state_q <= S_FOLD;
						end else begin
							dy_q <= dy_q + 1'b1;
						end
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				// fold the last read word before the result is taken
				S_FOLD: begin
					state_q <= S_LAST;
				end
				S_LAST: begin
					state_q <= cfg.max_mode ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("input taken while busy");
	ast_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_valid || out_ready)
		else $error("result loaded over a pending result");
	ast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_last))
		else $error("pending result dropped");
endmodule
